[src/tcpuex_pkg.sv]
// Shared types and constants of the CPU execute stage.
// Holds the request/result structs, the command and code tables and the
// state record passed between the execute logic and the top level.
package tcpuex_pkg;

  // Widths and sizes
  localparam int DATA_W    = 32;
  localparam int REG_COUNT = 13;
  localparam int REG_IDX_W = 4;
  localparam int CMD_W     = 5;
  localparam int IMM_W     = 26;
  localparam int IMM21_W   = 21;
  localparam int FLAGS_W   = 4;
  localparam int BUS_OP_W  = 3;
  localparam int FAULT_W   = 3;
  localparam int CFG_IDX_W = 1;

  // Special register indexes
  localparam logic [REG_IDX_W-1:0] IX_PC = 4'd8;
  localparam logic [REG_IDX_W-1:0] IX_SP = 4'd9;
  localparam logic [REG_IDX_W-1:0] IX_LR = 4'd12;
  localparam logic [REG_IDX_W-1:0] IX_LIMIT = 4'd13;

  // Flag bit positions
  localparam int FLAG_Z = 0;
  localparam int FLAG_C = 1;
  localparam int FLAG_S = 2;
  localparam int FLAG_V = 3;

  // Fixed values
  localparam logic [DATA_W-1:0] PORT_BASE      = 32'h2400_0000;
  localparam logic [DATA_W-1:0] PC_STEP        = 32'd4;
  localparam logic [DATA_W-1:0] STACK_BASE_RST = 32'h2000_0000;
  localparam logic [DATA_W-1:0] PROG_START_RST = 32'h0000_0000;
  localparam logic [7:0]        BYTE_MASK      = 8'hFF;

  // Commands
  localparam logic [CMD_W-1:0] CMD_MOV   = 5'd0;
  localparam logic [CMD_W-1:0] CMD_MOVI  = 5'd1;
  localparam logic [CMD_W-1:0] CMD_MOVIS = 5'd2;
  localparam logic [CMD_W-1:0] CMD_LD    = 5'd3;
  localparam logic [CMD_W-1:0] CMD_ST    = 5'd4;
  localparam logic [CMD_W-1:0] CMD_LDB   = 5'd5;
  localparam logic [CMD_W-1:0] CMD_STB   = 5'd6;
  localparam logic [CMD_W-1:0] CMD_ADD   = 5'd7;
  localparam logic [CMD_W-1:0] CMD_ADDIS = 5'd8;
  localparam logic [CMD_W-1:0] CMD_SUB   = 5'd9;
  localparam logic [CMD_W-1:0] CMD_CMP   = 5'd10;
  localparam logic [CMD_W-1:0] CMD_AND   = 5'd11;
  localparam logic [CMD_W-1:0] CMD_OR    = 5'd12;
  localparam logic [CMD_W-1:0] CMD_XOR   = 5'd13;
  localparam logic [CMD_W-1:0] CMD_SHL   = 5'd14;
  localparam logic [CMD_W-1:0] CMD_SHR   = 5'd15;
  localparam logic [CMD_W-1:0] CMD_CALL  = 5'd16;
  localparam logic [CMD_W-1:0] CMD_JMP   = 5'd17;
  localparam logic [CMD_W-1:0] CMD_JZ    = 5'd18;
  localparam logic [CMD_W-1:0] CMD_JNZ   = 5'd19;
  localparam logic [CMD_W-1:0] CMD_JG    = 5'd20;
  localparam logic [CMD_W-1:0] CMD_JL    = 5'd21;
  localparam logic [CMD_W-1:0] CMD_JA    = 5'd22;
  localparam logic [CMD_W-1:0] CMD_JB    = 5'd23;
  localparam logic [CMD_W-1:0] CMD_PUSH  = 5'd24;
  localparam logic [CMD_W-1:0] CMD_POP   = 5'd25;
  localparam logic [CMD_W-1:0] CMD_IN    = 5'd26;
  localparam logic [CMD_W-1:0] CMD_OUT   = 5'd27;
  localparam logic [CMD_W-1:0] CMD_HALT  = 5'd28;
  localparam logic [CMD_W-1:0] CMD_DEBUG = 5'd29;
  localparam logic [CMD_W-1:0] CMD_LDRET = 5'd30;
  localparam logic [CMD_W-1:0] CMD_BAD   = 5'd31;

  // Bus operations
  localparam logic [BUS_OP_W-1:0] BUS_NONE = 3'd0;
  localparam logic [BUS_OP_W-1:0] BUS_RDW  = 3'd1;
  localparam logic [BUS_OP_W-1:0] BUS_RDB  = 3'd2;
  localparam logic [BUS_OP_W-1:0] BUS_WRW  = 3'd3;
  localparam logic [BUS_OP_W-1:0] BUS_WRB  = 3'd4;

  // Fault codes
  localparam logic [FAULT_W-1:0] FLT_NONE  = 3'd0;
  localparam logic [FAULT_W-1:0] FLT_REG   = 3'd1;
  localparam logic [FAULT_W-1:0] FLT_OVER  = 3'd2;
  localparam logic [FAULT_W-1:0] FLT_UNDER = 3'd3;
  localparam logic [FAULT_W-1:0] FLT_CMD   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_BASE = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [REG_IDX_W-1:0] first_reg;
    logic [REG_IDX_W-1:0] second_reg;
    logic [IMM_W-1:0]     immediate;
    logic [DATA_W-1:0]    read_data;
  } in_item_t;

  typedef struct packed {
    logic [BUS_OP_W-1:0] bus_op;
    logic [DATA_W-1:0]   bus_address;
    logic [DATA_W-1:0]   bus_write_data;
    logic [DATA_W-1:0]   fetch_address;
    logic                halted_now;
    logic [FAULT_W-1:0]  fault;
  } out_item_t;

  // Architectural state kept in flops
  typedef struct packed {
    logic [DATA_W-1:0]    pc;
    logic [DATA_W-1:0]    sp;
    logic [FLAGS_W-1:0]   flags;
    logic                 stopped;
    logic                 ld_pend;
    logic [REG_IDX_W-1:0] ld_tgt;
    logic                 ld_byte;
    logic [DATA_W-1:0]    prog_start;
    logic [DATA_W-1:0]    stack_base;
  } arch_t;

  // Register file write request
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
  } wr_t;

endpackage

[src/tcpuex_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module tcpuex_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/tcpuex_regfile.sv]
// Register file of the execute stage: two RAM copies for two read ports,
// per-entry valid bits (unwritten entries read zero) and a write bypass.
// Depends on tcpuex_pkg and tcpuex_ram.
module tcpuex_regfile (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             rd_en,
  input  logic [tcpuex_pkg::REG_IDX_W-1:0] rd_idx1,
  input  logic [tcpuex_pkg::REG_IDX_W-1:0] rd_idx2,
  input  tcpuex_pkg::wr_t                  wr,
  output logic [tcpuex_pkg::DATA_W-1:0]    rd_data1,
  output logic [tcpuex_pkg::DATA_W-1:0]    rd_data2
);

  logic [tcpuex_pkg::REG_COUNT-1:0] vld_r;
  logic [tcpuex_pkg::REG_COUNT-1:0] vld_nxt;
  logic                             rvld1_r;
  logic                             rvld2_r;
  logic [tcpuex_pkg::REG_IDX_W-1:0] idx1_r;
  logic [tcpuex_pkg::REG_IDX_W-1:0] idx2_r;
  logic                             byp_vld_r;
  logic [tcpuex_pkg::REG_IDX_W-1:0] byp_idx_r;
  logic [tcpuex_pkg::DATA_W-1:0]    byp_data_r;
  logic [tcpuex_pkg::DATA_W-1:0]    ram_q1;
  logic [tcpuex_pkg::DATA_W-1:0]    ram_q2;
  logic                             wr_ok;

  assign wr_ok = wr.en && (wr.idx < tcpuex_pkg::IX_LIMIT);

  // Two copies, both written with every request
  tcpuex_ram #(
    .WIDTH(tcpuex_pkg::DATA_W),
    .DEPTH(tcpuex_pkg::REG_COUNT)
  ) u_ram1 (
    .clk  (clk),
    .we   (wr_ok),
    .waddr(wr.idx),
    .wdata(wr.data),
    .re   (rd_en),
    .raddr(rd_idx1),
    .rdata(ram_q1)
  );

  tcpuex_ram #(
    .WIDTH(tcpuex_pkg::DATA_W),
    .DEPTH(tcpuex_pkg::REG_COUNT)
  ) u_ram2 (
    .clk  (clk),
    .we   (wr_ok),
    .waddr(wr.idx),
    .wdata(wr.data),
    .re   (rd_en),
    .raddr(rd_idx2),
    .rdata(ram_q2)
  );

  // Mark entries as written
  always_comb begin
    vld_nxt = vld_r;
    if (wr_ok) begin
      vld_nxt[wr.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      byp_vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (rd_en) begin
        byp_vld_r <= wr_ok;
      end
    end
  end

  // Capture read context and the write that lands on the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      idx1_r     <= rd_idx1;
      idx2_r     <= rd_idx2;
      rvld1_r    <= (rd_idx1 < tcpuex_pkg::IX_LIMIT) ? vld_r[rd_idx1] : 1'b0;
      rvld2_r    <= (rd_idx2 < tcpuex_pkg::IX_LIMIT) ? vld_r[rd_idx2] : 1'b0;
      byp_idx_r  <= wr.idx;
      byp_data_r <= wr.data;
    end
  end

  // Resolve: bypass first, then RAM if written, else zero
  always_comb begin
    if (byp_vld_r && (byp_idx_r == idx1_r)) begin
      rd_data1 = byp_data_r;
    end else if (rvld1_r) begin
      rd_data1 = ram_q1;
    end else begin
      rd_data1 = '0;
    end
    if (byp_vld_r && (byp_idx_r == idx2_r)) begin
      rd_data2 = byp_data_r;
    end else if (rvld2_r) begin
      rd_data2 = ram_q2;
    end else begin
      rd_data2 = '0;
    end
  end

endmodule

[src/tcpuex_exec.sv]
// Combinational execute logic: one item against the current state gives the
// next state, a register write request and the result item.
// Depends on tcpuex_pkg.
module tcpuex_exec (
  input  tcpuex_pkg::in_item_t          item,
  input  tcpuex_pkg::arch_t             st,
  input  logic [tcpuex_pkg::DATA_W-1:0] rd_data1,
  input  logic [tcpuex_pkg::DATA_W-1:0] rd_data2,
  output tcpuex_pkg::arch_t             nxt,
  output tcpuex_pkg::wr_t               wr,
  output tcpuex_pkg::out_item_t         res
);

  logic [tcpuex_pkg::DATA_W-1:0]    pc4;
  logic [tcpuex_pkg::DATA_W-1:0]    val_a;
  logic [tcpuex_pkg::DATA_W-1:0]    val_b;
  logic [tcpuex_pkg::DATA_W-1:0]    imm_z21;
  logic [tcpuex_pkg::DATA_W-1:0]    imm_s21;
  logic [tcpuex_pkg::DATA_W-1:0]    off26;
  logic [tcpuex_pkg::DATA_W-1:0]    port_addr;
  logic [tcpuex_pkg::DATA_W:0]      diff;
  logic [tcpuex_pkg::DATA_W-1:0]    ld_val;
  logic                             use1;
  logic                             use2;
  logic                             bad1;
  logic                             bad2;
  logic                             take;
  logic                             dst_en;
  logic                             z_upd;
  logic [tcpuex_pkg::REG_IDX_W-1:0] dst_idx;
  logic [tcpuex_pkg::DATA_W-1:0]    dst_val;
  logic [tcpuex_pkg::FAULT_W-1:0]   flt;
  logic                             fz;
  logic                             fc;
  logic                             fs;
  logic                             fv;

  assign pc4       = st.pc + tcpuex_pkg::PC_STEP;
  assign imm_z21   = {{(tcpuex_pkg::DATA_W-tcpuex_pkg::IMM21_W){1'b0}},
                      item.immediate[tcpuex_pkg::IMM21_W-1:0]};
  assign imm_s21   = {{(tcpuex_pkg::DATA_W-tcpuex_pkg::IMM21_W)
                        {item.immediate[tcpuex_pkg::IMM21_W-1]}},
                      item.immediate[tcpuex_pkg::IMM21_W-1:0]};
  assign off26     = {{(tcpuex_pkg::DATA_W-tcpuex_pkg::IMM_W)
                        {item.immediate[tcpuex_pkg::IMM_W-1]}}, item.immediate};
  assign port_addr = tcpuex_pkg::PORT_BASE +
                     {{(tcpuex_pkg::DATA_W-tcpuex_pkg::IMM_W){1'b0}}, item.immediate};
  assign ld_val    = st.ld_byte ?
                     {{(tcpuex_pkg::DATA_W-8){1'b0}}, item.read_data[7:0] & tcpuex_pkg::BYTE_MASK}
                     : item.read_data;

  assign fz = st.flags[tcpuex_pkg::FLAG_Z];
  assign fc = st.flags[tcpuex_pkg::FLAG_C];
  assign fs = st.flags[tcpuex_pkg::FLAG_S];
  assign fv = st.flags[tcpuex_pkg::FLAG_V];

  // Operand select: PC reads as already advanced, SP from its flop
  always_comb begin
    if (item.first_reg == tcpuex_pkg::IX_PC) begin
      val_a = pc4;
    end else if (item.first_reg == tcpuex_pkg::IX_SP) begin
      val_a = st.sp;
    end else begin
      val_a = rd_data1;
    end
    if (item.second_reg == tcpuex_pkg::IX_PC) begin
      val_b = pc4;
    end else if (item.second_reg == tcpuex_pkg::IX_SP) begin
      val_b = st.sp;
    end else begin
      val_b = rd_data2;
    end
  end

  assign diff = {1'b0, val_a} - {1'b0, val_b};

  // Decode operand use and fault priority
  always_comb begin
    use1 = item.command inside {[tcpuex_pkg::CMD_MOV:tcpuex_pkg::CMD_SHR],
                                [tcpuex_pkg::CMD_PUSH:tcpuex_pkg::CMD_OUT]};
    use2 = item.command inside {tcpuex_pkg::CMD_MOV,
                                [tcpuex_pkg::CMD_LD:tcpuex_pkg::CMD_ADD],
                                [tcpuex_pkg::CMD_SUB:tcpuex_pkg::CMD_XOR]};
    bad1 = use1 && (item.first_reg >= tcpuex_pkg::IX_LIMIT);
    bad2 = use2 && (item.second_reg >= tcpuex_pkg::IX_LIMIT);
    if (item.command == tcpuex_pkg::CMD_BAD) begin
      flt = tcpuex_pkg::FLT_CMD;
    end else if ((item.command == tcpuex_pkg::CMD_POP) && (st.sp > st.stack_base)) begin
      flt = tcpuex_pkg::FLT_UNDER;
    end else if (bad1 || bad2) begin
      flt = tcpuex_pkg::FLT_REG;
    end else if ((item.command == tcpuex_pkg::CMD_PUSH) && (st.sp == st.prog_start)) begin
      flt = tcpuex_pkg::FLT_OVER;
    end else begin
      flt = tcpuex_pkg::FLT_NONE;
    end
  end

  // Execute one item
  always_comb begin
    nxt                = st;
    wr                 = '0;
    res                = '0;
    take               = 1'b0;
    dst_en             = 1'b0;
    z_upd              = 1'b0;
    dst_idx            = item.first_reg;
    dst_val            = '0;
    if (item.command == tcpuex_pkg::CMD_LDRET) begin
      // Complete a pending load even when stopped
      if (st.ld_pend && (st.ld_tgt < tcpuex_pkg::IX_LIMIT)) begin
        dst_en  = 1'b1;
        z_upd   = 1'b1;
        dst_idx = st.ld_tgt;
        dst_val = ld_val;
      end
      nxt.ld_pend = 1'b0;
    end else if (!st.stopped) begin
      nxt.pc = pc4;
      if (flt != tcpuex_pkg::FLT_NONE) begin
        nxt.stopped = 1'b1;
        res.fault   = flt;
      end else begin
        case (item.command)
          tcpuex_pkg::CMD_MOV: begin
            dst_en = 1'b1; z_upd = 1'b1; dst_val = val_b;
          end
          tcpuex_pkg::CMD_MOVI: begin
            dst_en = 1'b1; z_upd = 1'b1; dst_val = imm_z21;
          end
          tcpuex_pkg::CMD_MOVIS: begin
            dst_en = 1'b1; z_upd = 1'b1; dst_val = imm_s21;
          end
          tcpuex_pkg::CMD_LD: begin
            res.bus_op = tcpuex_pkg::BUS_RDW; res.bus_address = val_b;
            nxt.ld_pend = 1'b1; nxt.ld_tgt = item.first_reg; nxt.ld_byte = 1'b0;
          end
          tcpuex_pkg::CMD_ST: begin
            res.bus_op = tcpuex_pkg::BUS_WRW; res.bus_address = val_a;
            res.bus_write_data = val_b;
          end
          tcpuex_pkg::CMD_LDB: begin
            res.bus_op = tcpuex_pkg::BUS_RDB; res.bus_address = val_b;
            nxt.ld_pend = 1'b1; nxt.ld_tgt = item.first_reg; nxt.ld_byte = 1'b1;
          end
          tcpuex_pkg::CMD_STB: begin
            res.bus_op = tcpuex_pkg::BUS_WRB; res.bus_address = val_a;
            res.bus_write_data = {{(tcpuex_pkg::DATA_W-8){1'b0}},
                                  val_b[7:0] & tcpuex_pkg::BYTE_MASK};
          end
          tcpuex_pkg::CMD_ADD: begin
            dst_en = 1'b1; z_upd = 1'b1; dst_val = val_a + val_b;
          end
          tcpuex_pkg::CMD_ADDIS: begin
            dst_en = 1'b1; z_upd = 1'b1; dst_val = val_a + imm_s21;
          end
          tcpuex_pkg::CMD_SUB, tcpuex_pkg::CMD_CMP: begin
            // Set all four flags from the subtraction
            nxt.flags[tcpuex_pkg::FLAG_Z] = (diff[tcpuex_pkg::DATA_W-1:0] == '0);
            nxt.flags[tcpuex_pkg::FLAG_C] = diff[tcpuex_pkg::DATA_W];
            nxt.flags[tcpuex_pkg::FLAG_S] = diff[tcpuex_pkg::DATA_W-1];
            nxt.flags[tcpuex_pkg::FLAG_V] =
              (val_a[tcpuex_pkg::DATA_W-1] != val_b[tcpuex_pkg::DATA_W-1]) &&
              (val_a[tcpuex_pkg::DATA_W-1] != diff[tcpuex_pkg::DATA_W-1]);
            dst_en  = (item.command == tcpuex_pkg::CMD_SUB);
            dst_val = diff[tcpuex_pkg::DATA_W-1:0];
          end
          tcpuex_pkg::CMD_AND: begin
            dst_en = 1'b1; z_upd = 1'b1; dst_val = val_a & val_b;
          end
          tcpuex_pkg::CMD_OR: begin
            dst_en = 1'b1; z_upd = 1'b1; dst_val = val_a | val_b;
          end
          tcpuex_pkg::CMD_XOR: begin
            dst_en = 1'b1; z_upd = 1'b1; dst_val = val_a ^ val_b;
          end
          tcpuex_pkg::CMD_SHL: begin
            dst_en = 1'b1; z_upd = 1'b1; dst_val = {val_a[tcpuex_pkg::DATA_W-2:0], 1'b0};
          end
          tcpuex_pkg::CMD_SHR: begin
            dst_en = 1'b1; z_upd = 1'b1; dst_val = {1'b0, val_a[tcpuex_pkg::DATA_W-1:1]};
          end
          tcpuex_pkg::CMD_CALL: begin
            dst_en = 1'b1; dst_idx = tcpuex_pkg::IX_LR; dst_val = pc4; take = 1'b1;
          end
          tcpuex_pkg::CMD_JMP: take = 1'b1;
          tcpuex_pkg::CMD_JZ:  take = fz;
          tcpuex_pkg::CMD_JNZ: take = !fz;
          tcpuex_pkg::CMD_JG:  take = !fz && (fs == fv);
          tcpuex_pkg::CMD_JL:  take = (fs != fv);
          tcpuex_pkg::CMD_JA:  take = !fc && !fz;
          tcpuex_pkg::CMD_JB:  take = fc;
          tcpuex_pkg::CMD_PUSH: begin
            nxt.sp = st.sp - tcpuex_pkg::PC_STEP;
            res.bus_op = tcpuex_pkg::BUS_WRW;
            res.bus_address = st.sp - tcpuex_pkg::PC_STEP;
            res.bus_write_data = val_a;
          end
          tcpuex_pkg::CMD_POP: begin
            res.bus_op = tcpuex_pkg::BUS_RDW; res.bus_address = st.sp;
            nxt.sp = st.sp + tcpuex_pkg::PC_STEP;
            nxt.ld_pend = 1'b1; nxt.ld_tgt = item.first_reg; nxt.ld_byte = 1'b0;
          end
          tcpuex_pkg::CMD_IN: begin
            res.bus_op = tcpuex_pkg::BUS_RDW; res.bus_address = port_addr;
            nxt.ld_pend = 1'b1; nxt.ld_tgt = item.first_reg; nxt.ld_byte = 1'b0;
          end
          tcpuex_pkg::CMD_OUT: begin
            res.bus_op = tcpuex_pkg::BUS_WRW; res.bus_address = port_addr;
            res.bus_write_data = val_a;
          end
          tcpuex_pkg::CMD_HALT: nxt.stopped = 1'b1;
          default: ;
        endcase
      end
    end

    // Route the destination write: PC and SP live in flops
    if (dst_en) begin
      if (dst_idx == tcpuex_pkg::IX_PC) begin
        nxt.pc = dst_val;
      end else if (dst_idx == tcpuex_pkg::IX_SP) begin
        nxt.sp = dst_val;
      end else begin
        wr.en   = 1'b1;
        wr.idx  = dst_idx;
        wr.data = dst_val;
      end
    end
    if (z_upd) begin
      nxt.flags[tcpuex_pkg::FLAG_Z] = (dst_val == '0);
    end

    // Relative branch from the instruction's own address
    if (take) begin
      nxt.pc = st.pc + off26;
    end

    res.fetch_address = nxt.pc;
    res.halted_now    = nxt.stopped;
  end

endmodule

[src/toy_cpu_execute_unit.sv]
// Top level of the CPU execute stage: input register, state flops, result
// register and handshakes. Depends on tcpuex_pkg, tcpuex_regfile, tcpuex_exec.
//
// Usage:
//   in_*   : one request per item, an instruction or a load return (command 30).
//   out_*  : one result per item: bus request, next fetch address, halt, fault.
//   cfg_*  : writes program_start (index 0, also loads PC) or stack_base
//            (index 1, also loads SP); cfg_ready is always high. Write only
//            while no request is in flight.
// Timing: an accepted request executes in the execute register and its result
//   is registered as it leaves. One request per cycle is sustained while
//   out_ready is high; the register file read is taken at the accept edge
//   and a write landing on that edge is bypassed.
// Stall: while out_ready is low the result holds; once the execute register
//   is full, in_ready is low until the result moves.
// Reset: PC = program_start = 0, SP = stack_base = 0x20000000, flags, halt
//   and pending load cleared; general registers read zero until written
//   (per-entry valid bits, no clearing pass).
module toy_cpu_execute_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tcpuex_pkg::in_item_t                in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tcpuex_pkg::out_item_t               out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcpuex_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcpuex_pkg::DATA_W-1:0]       cfg_data
);

  logic                          ex_vld_r;
  tcpuex_pkg::in_item_t          ex_item_r;
  logic                          out_vld_r;
  tcpuex_pkg::out_item_t         out_data_r;
  tcpuex_pkg::arch_t             st_r;
  tcpuex_pkg::arch_t             st_nxt;
  tcpuex_pkg::arch_t             ex_nxt;
  tcpuex_pkg::wr_t               ex_wr;
  tcpuex_pkg::wr_t               rf_wr;
  tcpuex_pkg::out_item_t         ex_res;
  logic [tcpuex_pkg::DATA_W-1:0] rd_data1;
  logic [tcpuex_pkg::DATA_W-1:0] rd_data2;
  logic                          in_acc;
  logic                          ex_adv;
  logic                          cfg_acc;

  // Handshakes
  assign ex_adv    = ex_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !ex_vld_r || ex_adv;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Commit writes only when the item leaves the execute register
  always_comb begin
    rf_wr    = ex_wr;
    rf_wr.en = ex_wr.en && ex_adv;
  end

  tcpuex_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_idx1 (in_data.first_reg),
    .rd_idx2 (in_data.second_reg),
    .wr      (rf_wr),
    .rd_data1(rd_data1),
    .rd_data2(rd_data2)
  );

  tcpuex_exec u_exec (
    .item    (ex_item_r),
    .st      (st_r),
    .rd_data1(rd_data1),
    .rd_data2(rd_data2),
    .nxt     (ex_nxt),
    .wr      (ex_wr),
    .res     (ex_res)
  );

  // Next state: execute result, then configuration writes
  always_comb begin
    st_nxt = ex_adv ? ex_nxt : st_r;
    if (cfg_acc) begin
      case (cfg_index)
        tcpuex_pkg::CFG_PROG_START: begin
          st_nxt.prog_start = cfg_data;
          st_nxt.pc         = cfg_data;
        end
        tcpuex_pkg::CFG_STACK_BASE: begin
          st_nxt.stack_base = cfg_data;
          st_nxt.sp         = cfg_data;
        end
        default: ;
      endcase
    end
  end

  // State, valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r            <= '0;
      st_r.pc         <= tcpuex_pkg::PROG_START_RST;
      st_r.prog_start <= tcpuex_pkg::PROG_START_RST;
      st_r.sp         <= tcpuex_pkg::STACK_BASE_RST;
      st_r.stack_base <= tcpuex_pkg::STACK_BASE_RST;
      ex_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (in_acc) begin
        ex_vld_r <= 1'b1;
      end else if (ex_adv) begin
        ex_vld_r <= 1'b0;
      end
      if (ex_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ex_item_r <= in_data;
    end
    if (ex_adv) begin
      out_data_r <= ex_res;
    end
  end

`ifndef SYNTH
  // A faulting item always reports halt
  a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_data_r.fault != tcpuex_pkg::FLT_NONE) |-> out_data_r.halted_now)
    else $error("fault without halt");

  // No bus request means zero address and data
  a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_data_r.bus_op == tcpuex_pkg::BUS_NONE)
    |-> (out_data_r.bus_address == '0) && (out_data_r.bus_write_data == '0))
    else $error("stray bus address or data");

  // Instructions while stopped leave PC alone
  a_stopped_pc: assert property (@(posedge clk) disable iff (!rst_n)
    ex_adv && st_r.stopped && (ex_item_r.command != tcpuex_pkg::CMD_LDRET) && !cfg_acc
    |=> $stable(st_r.pc))
    else $error("PC moved while stopped");

  // A load return clears the pending record
  a_ldret_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ex_adv && (ex_item_r.command == tcpuex_pkg::CMD_LDRET) |=> !st_r.ld_pend)
    else $error("load still pending after return");

  // An executed item shows up as a result
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    ex_adv |=> out_vld_r)
    else $error("result lost");
`endif

endmodule
